/* hdl/pppg_pkg.sv */
// Package for the parametric path point generator.
// Holds field widths, fixed constants, the CORDIC angle table and the
// controller/datapath command and status types. No dependencies.
package pppg_pkg;

  localparam int TIME_W     = 17;
  localparam int FIELD_W    = 24;
  localparam int RAD_W      = 23;
  localparam int PHASE_W    = 16;
  localparam int HEAD_W     = 18;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int STEP_W     = 5;
  localparam int NUM_ANGLES = 24;

  localparam logic [TIME_W-1:0] TIME_ONE = 17'd65536;

  // Heading limits and the forward offset, degrees with 8 fraction bits.
  localparam logic signed [HEAD_W-1:0] HEAD_MIN = -18'sd23040;
  localparam logic signed [HEAD_W-1:0] HEAD_MAX = 18'sd69120;
  localparam logic signed [HEAD_W-1:0] HEAD_FWD = 18'sd23040;
  localparam logic signed [24:0]      DEG_Q8_PER_TURN = 25'sd92160;

  // CORDIC start vector, the inverse gain in Q30.
  localparam logic signed [31:0] CORDIC_X0 = 32'sd652032874;

  // Elementary rotation angles, 2^32 is one turn.
  localparam logic [31:0] ATAN_TURNS [NUM_ANGLES] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef enum logic [1:0] {
    MODE_CIRCLE  = 2'd0,
    MODE_ELLIPSE = 2'd1,
    MODE_SPIRAL  = 2'd2
  } path_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATH_MODE     = 3'd0,
    REG_CENTER_X      = 3'd1,
    REG_CENTER_Y      = 3'd2,
    REG_RADIUS_FIRST  = 3'd3,
    REG_RADIUS_SECOND = 3'd4,
    REG_START_PHASE   = 3'd5,
    REG_TILT_ANGLE    = 3'd6
  } cfg_reg_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_HDG, ST_VSTEP, ST_VMUL, ST_VUSE, ST_PRE, ST_RAD,
    ST_PLOAD, ST_PSTEP, ST_PLATCH, ST_C1, ST_C2, ST_C3,
    ST_E1, ST_E2, ST_E3, ST_TSTEP, ST_TLATCH,
    ST_E4, ST_E5, ST_E6, ST_E7, ST_E8, ST_DONE
  } ctl_state_e;

  typedef enum logic [2:0] {
    CR_IDLE, CR_LOAD_PATH, CR_LOAD_TILT, CR_LOAD_VEC,
    CR_ROT, CR_VEC, CR_LATCH_CS, CR_LATCH_TILT
  } cordic_op_e;

  typedef enum logic [3:0] {
    MUL_NONE, MUL_DR_T, MUL_R_COS, MUL_R_SIN, MUL_R1_COS, MUL_R2_SIN,
    MUL_EX_CT, MUL_EY_ST, MUL_EX_ST, MUL_EY_CT, MUL_Z_DEG
  } mul_sel_e;

  typedef enum logic [3:0] {
    USE_NONE, USE_RADIUS, USE_EX, USE_EY, USE_PX, USE_PY,
    USE_ACC_LOAD, USE_ACC_PX, USE_ACC_PY_SUB, USE_HEAD
  } use_sel_e;

  typedef struct packed {
    logic              accept;
    cordic_op_e        cordic_op;
    logic [STEP_W-1:0] step;
    mul_sel_e          mul_sel;
    use_sel_e          use_sel;
    logic              head_plain;
    logic              finish;
  } dp_cmd_t;

  typedef struct packed {
    logic head_need;
    logic is_ellipse;
    logic is_spiral;
    logic out_free;
  } dp_status_t;

endpackage

/* hdl/pppg_ifs.sv */
// Handshake channel interfaces of the path point generator.
// Depends on pppg_pkg for the field widths.
interface pppg_in_if import pppg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] time_fraction;
  modport source (output valid, output time_fraction, input ready);
  modport sink   (input valid, input time_fraction, output ready);
endinterface

interface pppg_out_if import pppg_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] pos_x;
  logic signed [FIELD_W-1:0] pos_y;
  logic signed [HEAD_W-1:0]  heading_deg;
  logic                      heading_valid;
  modport source (output valid, output pos_x, output pos_y, output heading_deg,
                  output heading_valid, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input heading_deg,
                  input heading_valid, output ready);
endinterface

interface pppg_cfg_if import pppg_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* hdl/parametric_path_point_generator.sv */
// Top level of the parametric path point generator (circle, ellipse, spiral).
// Depends on pppg_pkg, the channel interfaces, pppg_ctrl and pppg_datapath.
//
//   channel  direction  payload
//   in_ch    sink       time_fraction
//   out_ch   source     pos_x, pos_y, heading_deg, heading_valid
//   cfg_ch   sink       index, data (register write, always ready)
//
// Each word runs the path sine/cosine rotation; ellipse words add a tilt rotation,
// spiral words a radius update, and a heading arctangent runs first when needed.
// One shared iterative CORDIC, one step per cycle, runs the arctangent and each
// sine/cosine pair. Reset clears configuration, point history and output valid.
// A result held by a stalled out_ch does not block the next input word;
// only the hand-over of the following result waits for it.
module parametric_path_point_generator import pppg_pkg::*; #(
  parameter int CORDIC_STEPS = 16,
  parameter int COORD_BITS   = 24
) (
  input logic       clk_i,
  input logic       rst_ni,
  pppg_in_if.sink   in_ch,
  pppg_out_if.source out_ch,
  pppg_cfg_if.sink  cfg_ch
);

  dp_cmd_t    cmd;
  dp_status_t sts;

  assign cfg_ch.ready = 1'b1;

  pppg_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pppg_datapath #(
    .COORD_BITS(COORD_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_ch.valid),
    .cfg_idx_i    (cfg_ch.index),
    .cfg_data_i   (cfg_ch.data),
    .time_i       (in_ch.time_fraction),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_ready_i  (out_ch.ready),
    .out_valid_o  (out_ch.valid),
    .pos_x_o      (out_ch.pos_x),
    .pos_y_o      (out_ch.pos_y),
    .head_o       (out_ch.heading_deg),
    .head_valid_o (out_ch.heading_valid)
  );

endmodule

/* hdl/pppg_ctrl.sv */
// Sequencing controller of the path point generator.
// Depends on pppg_pkg; drives the datapath by dp_cmd_t, reads dp_status_t.
module pppg_ctrl import pppg_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t sts_i,
  output dp_cmd_t    cmd_o
);

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

  ctl_state_e        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              last_step;

  assign last_step = (step_q == LAST_STEP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    in_ready_o = 1'b0;
    cmd_o      = '{accept: 1'b0, cordic_op: CR_IDLE, step: step_q, mul_sel: MUL_NONE,
                   use_sel: USE_NONE, head_plain: 1'b0, finish: 1'b0};
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_HDG;
        end
      end
      ST_HDG: begin
        step_d = '0;
        if (sts_i.head_need) begin
          cmd_o.cordic_op = CR_LOAD_VEC;
          state_d         = ST_VSTEP;
        end else begin
          cmd_o.head_plain = 1'b1;
          state_d          = ST_PRE;
        end
      end
      ST_VSTEP: begin
        cmd_o.cordic_op = CR_VEC;
        step_d          = step_q + 1'b1;
        if (last_step) state_d = ST_VMUL;
      end
      ST_VMUL: begin
        cmd_o.mul_sel = MUL_Z_DEG;
        state_d       = ST_VUSE;
      end
      ST_VUSE: begin
        cmd_o.use_sel = USE_HEAD;
        state_d       = ST_PRE;
      end
      ST_PRE: begin
        cmd_o.mul_sel = MUL_DR_T;
        state_d       = sts_i.is_spiral ? ST_RAD : ST_PLOAD;
      end
      ST_RAD: begin
        cmd_o.use_sel = USE_RADIUS;
        state_d       = ST_PLOAD;
      end
      ST_PLOAD: begin
        cmd_o.cordic_op = CR_LOAD_PATH;
        step_d          = '0;
        state_d         = ST_PSTEP;
      end
      ST_PSTEP: begin
        cmd_o.cordic_op = CR_ROT;
        step_d          = step_q + 1'b1;
        if (last_step) state_d = ST_PLATCH;
      end
      ST_PLATCH: begin
        cmd_o.cordic_op = CR_LATCH_CS;
        state_d         = sts_i.is_ellipse ? ST_E1 : ST_C1;
      end
      ST_C1: begin
        cmd_o.mul_sel = MUL_R_COS;
        state_d       = ST_C2;
      end
      ST_C2: begin
        cmd_o.use_sel = USE_PX;
        cmd_o.mul_sel = MUL_R_SIN;
        state_d       = ST_C3;
      end
      ST_C3: begin
        cmd_o.use_sel = USE_PY;
        state_d       = ST_DONE;
      end
      ST_E1: begin
        cmd_o.mul_sel = MUL_R1_COS;
        state_d       = ST_E2;
      end
      ST_E2: begin
        cmd_o.use_sel = USE_EX;
        cmd_o.mul_sel = MUL_R2_SIN;
        state_d       = ST_E3;
      end
      ST_E3: begin
        cmd_o.use_sel   = USE_EY;
        cmd_o.cordic_op = CR_LOAD_TILT;
        step_d          = '0;
        state_d         = ST_TSTEP;
      end
      ST_TSTEP: begin
        cmd_o.cordic_op = CR_ROT;
        step_d          = step_q + 1'b1;
        if (last_step) state_d = ST_TLATCH;
      end
      ST_TLATCH: begin
        cmd_o.cordic_op = CR_LATCH_TILT;
        state_d         = ST_E4;
      end
      ST_E4: begin
        cmd_o.mul_sel = MUL_EX_CT;
        state_d       = ST_E5;
      end
      ST_E5: begin
        cmd_o.use_sel = USE_ACC_LOAD;
        cmd_o.mul_sel = MUL_EY_ST;
        state_d       = ST_E6;
      end
      ST_E6: begin
        cmd_o.use_sel = USE_ACC_PX;
        cmd_o.mul_sel = MUL_EX_ST;
        state_d       = ST_E7;
      end
      ST_E7: begin
        cmd_o.use_sel = USE_ACC_LOAD;
        cmd_o.mul_sel = MUL_EY_CT;
        state_d       = ST_E8;
      end
      ST_E8: begin
        cmd_o.use_sel = USE_ACC_PY_SUB;
        state_d       = ST_DONE;
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // The step counter never runs past the last CORDIC iteration.
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_VSTEP || state_q == ST_PSTEP || state_q == ST_TSTEP)
      |-> step_q <= LAST_STEP)
    else $error("CORDIC step counter out of range");

  // A finished point leaves the controller as soon as the output word is free.
  a_done_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && sts_i.out_free) |=> state_q == ST_IDLE)
    else $error("point not handed over when output was free");

  // An accepted word always starts with the heading decision.
  a_accept_hdg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> state_q == ST_HDG)
    else $error("accept did not start a new point");

endmodule

/* hdl/pppg_datapath.sv */
// Datapath of the path point generator: configuration registers, the shared
// CORDIC unit, the shared multiplier, point history and the output register.
// Depends on pppg_pkg; commanded by pppg_ctrl.
module pppg_datapath import pppg_pkg::*; #(
  parameter int COORD_BITS = 24
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]     cfg_data_i,
  input  logic [TIME_W-1:0]         time_i,
  input  dp_cmd_t                   cmd_i,
  output dp_status_t                sts_o,
  input  logic                      out_ready_i,
  output logic                      out_valid_o,
  output logic signed [FIELD_W-1:0] pos_x_o,
  output logic signed [FIELD_W-1:0] pos_y_o,
  output logic signed [HEAD_W-1:0]  head_o,
  output logic                      head_valid_o
);

  localparam int XW = COORD_BITS + 24;  // CORDIC x and y
  localparam int ZW = 34;               // CORDIC angle with headroom
  localparam int PW = 60;               // product of 25 by 35 bits
  localparam int AW = 61;
  localparam int SW = 35;               // center sum
  localparam int DW = COORD_BITS + 1;   // point difference

  localparam logic signed [AW-1:0] HALF30 = AW'(64'sd536870912);
  localparam logic signed [PW-1:0] HALF32 = PW'(64'sd2147483648);
  localparam logic signed [PW-1:0] HALF16 = PW'(64'sd32768);
  localparam logic signed [ZW-1:0] QUARTER = ZW'(64'sd1073741824);
  localparam logic signed [ZW-1:0] HALF_TURN = ZW'(64'sd2147483648);
  localparam logic signed [SW-1:0] C_HI = SW'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] C_LO = -C_HI - SW'(64'sd1);

  // Configuration.
  logic [1:0]                mode_q;
  logic signed [FIELD_W-1:0] cen_x_q, cen_y_q;
  logic [RAD_W-1:0]          r1_q, r2_q;
  logic [PHASE_W-1:0]        start_q, tilt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= '0;
      cen_x_q <= '0;
      cen_y_q <= '0;
      r1_q    <= '0;
      r2_q    <= '0;
      start_q <= '0;
      tilt_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PATH_MODE:     mode_q  <= cfg_data_i[1:0];
        REG_CENTER_X:      cen_x_q <= cfg_data_i;
        REG_CENTER_Y:      cen_y_q <= cfg_data_i;
        REG_RADIUS_FIRST:  r1_q    <= cfg_data_i[RAD_W-1:0];
        REG_RADIUS_SECOND: r2_q    <= cfg_data_i[RAD_W-1:0];
        REG_START_PHASE:   start_q <= cfg_data_i[PHASE_W-1:0];
        REG_TILT_ANGLE:    tilt_q  <= cfg_data_i[PHASE_W-1:0];
        default: ;
      endcase
    end
  end

  logic is_ellipse, is_spiral;
  assign is_ellipse = (mode_q == 2'(MODE_ELLIPSE));
  assign is_spiral  = (mode_q == 2'(MODE_SPIRAL));

  // Point history.
  logic signed [COORD_BITS-1:0] recent_x_q, recent_y_q, older_x_q, older_y_q;
  logic [1:0]                   seen_q;
  logic signed [DW-1:0]         dx, dy;
  logic                         two_seen;

  assign dx       = DW'(recent_x_q) - DW'(older_x_q);
  assign dy       = DW'(recent_y_q) - DW'(older_y_q);
  assign two_seen = seen_q[1];

  // Working registers.
  logic [TIME_W-1:0]     t_q;
  logic signed [24:0]    r_q, ex_q, ey_q;
  logic signed [XW-1:0]  cx_q, cy_q;
  logic signed [ZW-1:0]  cz_q;
  logic                  flip_q;
  logic signed [31:0]    cos_q, sin_q, ct_q, st_q;
  logic signed [PW-1:0]  prod_q;
  logic signed [AW-1:0]  acc_q;
  logic signed [33:0]    px_q, py_q;
  logic signed [HEAD_W-1:0] head_q;
  logic                  hv_q;

  // Path angle and the folded CORDIC start angle.
  logic [PHASE_W-1:0]   phase;
  logic signed [ZW-1:0] ang, ang_fold;
  logic                 ang_flip;

  always_comb begin
    if (is_ellipse) begin
      phase = t_q[PHASE_W-1:0];
    end else if (is_spiral) begin
      phase = start_q + PHASE_W'(t_q * 2'd3);
    end else begin
      phase = start_q + t_q[PHASE_W-1:0];
    end
    if (cmd_i.cordic_op == CR_LOAD_TILT) begin
      ang = ZW'($signed({tilt_q, 16'h0000}));
    end else begin
      ang = ZW'($signed({phase, 16'h0000}));
    end
    ang_flip = 1'b1;
    if (ang > QUARTER) begin
      ang_fold = ang - HALF_TURN;
    end else if (ang < -QUARTER) begin
      ang_fold = ang + HALF_TURN;
    end else begin
      ang_fold = ang;
      ang_flip = 1'b0;
    end
  end

  // One CORDIC iteration.
  logic signed [XW-1:0] xs, ys, vx0, vy0;
  logic signed [ZW-1:0] atan_i;
  assign xs     = cx_q >>> cmd_i.step;
  assign ys     = cy_q >>> cmd_i.step;
  assign atan_i = ZW'(ATAN_TURNS[cmd_i.step]);
  assign vx0    = XW'(dx) <<< 20;
  assign vy0    = XW'(dy) <<< 20;

  always_ff @(posedge clk_i) begin
    case (cmd_i.cordic_op)
      CR_LOAD_PATH, CR_LOAD_TILT: begin
        cx_q   <= XW'(CORDIC_X0);
        cy_q   <= '0;
        cz_q   <= ang_fold;
        flip_q <= ang_flip;
      end
      CR_LOAD_VEC: begin
        if (dx < 0) begin
          if (dy >= 0) begin
            cx_q <= vy0;
            cy_q <= -vx0;
            cz_q <= QUARTER;
          end else begin
            cx_q <= -vy0;
            cy_q <= vx0;
            cz_q <= -QUARTER;
          end
        end else begin
          cx_q <= vx0;
          cy_q <= vy0;
          cz_q <= '0;
        end
      end
      CR_ROT: begin
        if (!cz_q[ZW-1]) begin
          cx_q <= cx_q - ys;
          cy_q <= cy_q + xs;
          cz_q <= cz_q - atan_i;
        end else begin
          cx_q <= cx_q + ys;
          cy_q <= cy_q - xs;
          cz_q <= cz_q + atan_i;
        end
      end
      CR_VEC: begin
        if (!cy_q[XW-1]) begin
          cx_q <= cx_q + ys;
          cy_q <= cy_q - xs;
          cz_q <= cz_q + atan_i;
        end else begin
          cx_q <= cx_q - ys;
          cy_q <= cy_q + xs;
          cz_q <= cz_q - atan_i;
        end
      end
      CR_LATCH_CS: begin
        cos_q <= flip_q ? -32'(cx_q) : 32'(cx_q);
        sin_q <= flip_q ? -32'(cy_q) : 32'(cy_q);
      end
      CR_LATCH_TILT: begin
        ct_q <= flip_q ? -32'(cx_q) : 32'(cx_q);
        st_q <= flip_q ? -32'(cy_q) : 32'(cy_q);
      end
      default: ;
    endcase
  end

  // Shared multiplier with registered product.
  logic signed [24:0]   mul_a;
  logic signed [34:0]   mul_b;
  logic signed [PW-1:0] mul_p;
  logic signed [ZW-1:0] z_clamp;

  always_comb begin
    if (cz_q > HALF_TURN) begin
      z_clamp = HALF_TURN;
    end else if (cz_q < -HALF_TURN) begin
      z_clamp = -HALF_TURN;
    end else begin
      z_clamp = cz_q;
    end
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.mul_sel)
      MUL_DR_T: begin
        mul_a = 25'($signed({1'b0, r2_q})) - 25'($signed({1'b0, r1_q}));
        mul_b = 35'($signed({1'b0, t_q}));
      end
      MUL_R_COS:  begin mul_a = r_q;  mul_b = 35'(cos_q); end
      MUL_R_SIN:  begin mul_a = r_q;  mul_b = 35'(sin_q); end
      MUL_R1_COS: begin mul_a = 25'($signed({1'b0, r1_q})); mul_b = 35'(cos_q); end
      MUL_R2_SIN: begin mul_a = 25'($signed({1'b0, r2_q})); mul_b = 35'(sin_q); end
      MUL_EX_CT:  begin mul_a = ex_q; mul_b = 35'(ct_q); end
      MUL_EY_ST:  begin mul_a = ey_q; mul_b = 35'(st_q); end
      MUL_EX_ST:  begin mul_a = ex_q; mul_b = 35'(st_q); end
      MUL_EY_CT:  begin mul_a = ey_q; mul_b = 35'(ct_q); end
      MUL_Z_DEG:  begin mul_a = DEG_Q8_PER_TURN; mul_b = 35'(z_clamp); end
      default: ;
    endcase
  end

  // The full-width product is formed before it is registered.
  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;
  end

  // Consumers of the product.
  logic signed [AW-1:0]     rnd_p, rnd_sum, rnd_dif;
  logic signed [PW-1:0]     deg_full;
  logic signed [HEAD_W:0]   head_raw;

  assign rnd_p    = (AW'(prod_q) + HALF30) >>> 30;
  assign rnd_sum  = (acc_q + AW'(prod_q) + HALF30) >>> 30;
  assign rnd_dif  = (acc_q - AW'(prod_q) + HALF30) >>> 30;
  assign deg_full = (prod_q + HALF32) >>> 32;
  assign head_raw = (HEAD_W+1)'(HEAD_FWD) - (HEAD_W+1)'(deg_full);

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      t_q  <= (time_i > TIME_ONE) ? TIME_ONE : time_i;
      r_q  <= 25'($signed({1'b0, r1_q}));
      hv_q <= two_seen;
    end
    if (cmd_i.head_plain) begin
      if (!hv_q) begin
        head_q <= '0;
      end else begin
        head_q <= (dx < 0) ? -HEAD_FWD : HEAD_FWD;
      end
    end
    case (cmd_i.use_sel)
      USE_RADIUS:     r_q   <= 25'($signed({1'b0, r1_q})) + 25'((prod_q + HALF16) >>> 16);
      USE_EX:         ex_q  <= 25'(rnd_p);
      USE_EY:         ey_q  <= 25'(rnd_p);
      USE_PX:         px_q  <= 34'(rnd_p);
      USE_PY:         py_q  <= 34'(rnd_p);
      USE_ACC_LOAD:   acc_q <= AW'(prod_q);
      USE_ACC_PX:     px_q  <= 34'(rnd_sum);
      USE_ACC_PY_SUB: py_q  <= 34'(rnd_dif);
      USE_HEAD: begin
        if (head_raw < (HEAD_W+1)'(HEAD_MIN)) begin
          head_q <= HEAD_MIN;
        end else if (head_raw > (HEAD_W+1)'(HEAD_MAX)) begin
          head_q <= HEAD_MAX;
        end else begin
          head_q <= HEAD_W'(head_raw);
        end
      end
      default: ;
    endcase
  end

  // Center offset and saturation.
  logic signed [SW-1:0] sum_x, sum_y, sat_x, sat_y;
  assign sum_x = SW'(px_q) + SW'(cen_x_q);
  assign sum_y = SW'(py_q) + SW'(cen_y_q);
  assign sat_x = (sum_x > C_HI) ? C_HI : ((sum_x < C_LO) ? C_LO : sum_x);
  assign sat_y = (sum_y > C_HI) ? C_HI : ((sum_y < C_LO) ? C_LO : sum_y);

  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recent_x_q  <= '0;
      recent_y_q  <= '0;
      older_x_q   <= '0;
      older_y_q   <= '0;
      seen_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.finish) begin
        older_x_q   <= recent_x_q;
        older_y_q   <= recent_y_q;
        recent_x_q  <= COORD_BITS'(sat_x);
        recent_y_q  <= COORD_BITS'(sat_y);
        seen_q      <= two_seen ? seen_q : seen_q + 2'd1;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      pos_x_o      <= FIELD_W'(sat_x);
      pos_y_o      <= FIELD_W'(sat_y);
      head_o       <= head_q;
      head_valid_o <= hv_q;
    end
  end

  assign out_valid_o = out_valid_q;

  assign sts_o = '{head_need: two_seen && (dy != 0), is_ellipse: is_ellipse,
                   is_spiral: is_spiral, out_free: !out_valid_q || out_ready_i};

endmodule

/* tb/tb_parametric_path_point_generator.sv */
// Self-checking testbench of the parametric path point generator.
// Depends on pppg_pkg, the channel interfaces and the top level of the block.
// Directed rows, register extremes, then random time words, checked against a built-in predictor or typed points.
module tb_parametric_path_point_generator;
  import pppg_pkg::*;

  localparam int  NUM_RANDOM   = 1900;
  localparam longint CYCLE_LIMIT = 1200000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #5 clk_i = ~clk_i;

  pppg_in_if  in_ch ();
  pppg_out_if out_ch ();
  pppg_cfg_if cfg_ch ();

  parametric_path_point_generator DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  typedef struct packed {
    logic signed [FIELD_W-1:0] pos_x;
    logic signed [FIELD_W-1:0] pos_y;
    logic signed [HEAD_W-1:0]  heading_deg;
    logic                      heading_valid;
  } point_t;

  // Directed row: time word, and an optional hand-typed expected point.
  typedef struct {
    logic [TIME_W-1:0] tval;
    logic              typed;
    point_t            want;
  } dir_row_t;

  // Predictor copy of configuration and point history.
  logic [1:0]   m_mode;
  longint       m_cx, m_cy, m_r1, m_r2;
  longint       m_phase, m_tilt;
  longint       m_rx, m_ry, m_ox, m_oy;
  int           m_seen;

  point_t       pending_points [$];
  int           fail_count = 0;
  longint       cycle_count = 0;
  logic         out_noidle = 1'b0;

  function automatic longint asr(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint sext(longint v, int w);
    longint m;
    m = (longint'(1) << w) - 1;
    v = v & m;
    if (v[w-1]) return v | ~m;
    return v;
  endfunction

  function automatic longint mul_round(longint a, longint f);
    return asr(a * f + (longint'(1) << 29), 30);
  endfunction

  task automatic cordic_sincos(input longint ang, output longint c, output longint s);
    longint z, x, y, nx, ny;
    logic flip;
    z = (ang >= 64'h8000_0000) ? ang - (longint'(1) << 32) : ang;
    x = CORDIC_X0;
    y = 0;
    flip = 1'b0;
    if (z > (longint'(1) << 30)) begin
      z -= longint'(1) << 31; flip = 1'b1;
    end else if (z < -(longint'(1) << 30)) begin
      z += longint'(1) << 31; flip = 1'b1;
    end
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        nx = x - asr(y, i); ny = y + asr(x, i); z -= longint'(ATAN_TURNS[i]);
      end else begin
        nx = x + asr(y, i); ny = y - asr(x, i); z += longint'(ATAN_TURNS[i]);
      end
      x = nx; y = ny;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic longint bearing_deg(longint dx, longint dy);
    longint x, y, z, t, nx, ny;
    if (dy == 0) return (dx < 0) ? 46080 : 0;
    x = dx * (longint'(1) << 20);
    y = dy * (longint'(1) << 20);
    z = 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = longint'(1) << 30;
      end else begin
        t = x; x = -y; y = t; z = -(longint'(1) << 30);
      end
    end
    for (int i = 0; i < 16; i++) begin
      if (y >= 0) begin
        nx = x + asr(y, i); ny = y - asr(x, i); z += longint'(ATAN_TURNS[i]);
      end else begin
        nx = x - asr(y, i); ny = y + asr(x, i); z -= longint'(ATAN_TURNS[i]);
      end
      x = nx; y = ny;
    end
    if (z > (longint'(1) << 31)) z = longint'(1) << 31;
    if (z < -(longint'(1) << 31)) z = -(longint'(1) << 31);
    return asr(z * 92160 + (longint'(1) << 31), 32);
  endfunction

  function automatic longint clamp_coord(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  task automatic apply_register(input cfg_reg_e idx, input longint val);
    case (idx)
      REG_PATH_MODE:     m_mode = val[1:0];
      REG_CENTER_X:      m_cx = sext(val, 24);
      REG_CENTER_Y:      m_cy = sext(val, 24);
      REG_RADIUS_FIRST:  m_r1 = val & 64'h7F_FFFF;
      REG_RADIUS_SECOND: m_r2 = val & 64'h7F_FFFF;
      REG_START_PHASE:   m_phase = val & 64'hFFFF;
      REG_TILT_ANGLE:    m_tilt = val & 64'hFFFF;
      default: ;
    endcase
  endtask

  task automatic predict_point(input logic [TIME_W-1:0] tin, output point_t p);
    longint t, c, s, ct, st, ex, ey, px, py, head, r, ph;
    logic   valid;
    t = tin;
    valid = (m_seen >= 2);
    head = 0;
    if (t > 65536) t = 65536;
    if (m_mode == MODE_ELLIPSE) begin
      ph = (t & 64'hFFFF) << 16;
      cordic_sincos(ph, c, s);
      ex = mul_round(m_r1, c);
      ey = mul_round(m_r2, s);
      cordic_sincos(m_tilt << 16, ct, st);
      px = asr(ex * ct + ey * st + (longint'(1) << 29), 30);
      py = asr(ex * st - ey * ct + (longint'(1) << 29), 30);
    end else if (m_mode == MODE_SPIRAL) begin
      r = m_r1 + asr((m_r2 - m_r1) * t + 32768, 16);
      ph = ((m_phase + 3 * t) & 64'hFFFF) << 16;
      cordic_sincos(ph, c, s);
      px = mul_round(r, c);
      py = mul_round(r, s);
    end else begin
      ph = ((m_phase + t) & 64'hFFFF) << 16;
      cordic_sincos(ph, c, s);
      px = mul_round(m_r1, c);
      py = mul_round(m_r1, s);
    end
    px = clamp_coord(px + m_cx);
    py = clamp_coord(py + m_cy);
    if (valid) begin
      head = 23040 - bearing_deg(m_rx - m_ox, m_ry - m_oy);
      if (head < -23040) head = -23040;
      if (head > 69120) head = 69120;
    end
    m_ox = m_rx; m_oy = m_ry;
    m_rx = px;   m_ry = py;
    if (m_seen < 2) m_seen++;
    p.pos_x = px[23:0];
    p.pos_y = py[23:0];
    p.heading_deg = head[17:0];
    p.heading_valid = valid;
  endtask

  // Output side: random stalls, checking of every accepted word.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= out_noidle || ($urandom_range(99) >= 18);
    end
  end

  always @(posedge clk_i) begin
    point_t w;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_points.size() == 0) begin
        $error("unexpected output word x=%0d y=%0d", out_ch.pos_x, out_ch.pos_y);
        fail_count++;
      end else begin
        w = pending_points.pop_front();
        if (out_ch.pos_x !== w.pos_x) begin
          $error("pos_x expected %0d actual %0d", w.pos_x, out_ch.pos_x);
          fail_count++;
        end
        if (out_ch.pos_y !== w.pos_y) begin
          $error("pos_y expected %0d actual %0d", w.pos_y, out_ch.pos_y);
          fail_count++;
        end
        if (out_ch.heading_deg !== w.heading_deg) begin
          $error("heading_deg expected %0d actual %0d", w.heading_deg, out_ch.heading_deg);
          fail_count++;
        end
        if (out_ch.heading_valid !== w.heading_valid) begin
          $error("heading_valid expected %0d actual %0d", w.heading_valid,
                 out_ch.heading_valid);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("parametric_path_point_generator verification failed");
      $finish;
    end
  end

  // Each write drops valid again after it is taken, so consecutive writes
  // never drive valid twice at the same edge.
  task automatic write_register(input cfg_reg_e idx, input longint val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val[23:0];
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    apply_register(idx, val);
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_time(input logic [TIME_W-1:0] tval, input logic noidle);
    point_t p;
    if (!noidle) begin
      while ($urandom_range(99) < 18) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.time_fraction <= tval;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    predict_point(tval, p);
    pending_points.push_back(p);
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_typed(input logic [TIME_W-1:0] tval, input point_t want);
    point_t p;
    in_ch.valid <= 1'b1;
    in_ch.time_fraction <= tval;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    predict_point(tval, p);
    pending_points.push_back(want);
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Waits until every expected word has come, plus a settling margin.
  task automatic drain_results();
    while (pending_points.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic random_config();
    write_register(REG_PATH_MODE, $urandom_range(3));
    write_register(REG_CENTER_X, ($urandom_range(3) == 0) ? $urandom : $urandom_range(8191));
    write_register(REG_CENTER_Y, ($urandom_range(3) == 0) ? $urandom : $urandom_range(8191));
    write_register(REG_RADIUS_FIRST, ($urandom_range(3) == 0) ? $urandom : $urandom_range(65535));
    write_register(REG_RADIUS_SECOND, ($urandom_range(3) == 0) ? $urandom : $urandom_range(65535));
    write_register(REG_START_PHASE, $urandom);
    write_register(REG_TILT_ANGLE, $urandom);
  endtask

  function automatic logic [TIME_W-1:0] random_time();
    case ($urandom_range(9))
      0:       return TIME_W'(TIME_ONE + $urandom_range(65535));
      1:       return 17'h1FFFF;
      2:       return TIME_ONE;
      default: return TIME_W'($urandom_range(65536));
    endcase
  endfunction

  dir_row_t dir_rows [$];

  function automatic dir_row_t row(input logic [TIME_W-1:0] t, input logic typed,
                                    input point_t want);
    dir_row_t r;
    r.tval = t; r.typed = typed; r.want = want;
    return r;
  endfunction

  initial begin
    in_ch.valid = 1'b0;
    in_ch.time_fraction = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_PATH_MODE;
    cfg_ch.data = '0;
    m_mode = MODE_CIRCLE;
    m_cx = 0; m_cy = 0; m_r1 = 0; m_r2 = 0; m_phase = 0; m_tilt = 0;
    m_rx = 0; m_ry = 0; m_ox = 0; m_oy = 0; m_seen = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // After reset every radius is zero: points sit at the origin, the first two
    // carry no heading and zero motion gives 90 degrees after that.
    dir_rows.push_back(row(17'd0, 1'b1, '{24'sd0, 24'sd0, 18'sd0, 1'b0}));
    dir_rows.push_back(row(17'h1FFFF, 1'b1, '{24'sd0, 24'sd0, 18'sd0, 1'b0}));
    dir_rows.push_back(row(TIME_ONE, 1'b1, '{24'sd0, 24'sd0, 18'sd23040, 1'b1}));
    foreach (dir_rows[i]) begin
      if (dir_rows[i].typed) send_typed(dir_rows[i].tval, dir_rows[i].want);
      else send_time(dir_rows[i].tval, 1'b0);
    end
    drain_results();

    // Extremes of every register, each mode including the unused one.
    for (int m = 0; m < 4; m++) begin
      write_register(REG_PATH_MODE, m);
      write_register(REG_CENTER_X, (m[0]) ? 24'h7FFFFF : 24'h800000);
      write_register(REG_CENTER_Y, (m[1]) ? 24'h800000 : 24'h7FFFFF);
      write_register(REG_RADIUS_FIRST, 23'h7FFFFF);
      write_register(REG_RADIUS_SECOND, (m == 2) ? 0 : 23'h7FFFFF);
      write_register(REG_START_PHASE, 16'hFFFF);
      write_register(REG_TILT_ANGLE, (m == 1) ? 16'h4000 : 16'hFFFF);
      send_time(17'd0, 1'b0);
      send_time(17'd16384, 1'b0);
      send_time(17'd32768, 1'b0);
      send_time(TIME_ONE, 1'b0);
      send_time(17'h1FFFF, 1'b0);
      drain_results();
    end

    // Horizontal leftward motion: small circle at half turn steps.
    write_register(REG_PATH_MODE, MODE_CIRCLE);
    write_register(REG_CENTER_X, 0);
    write_register(REG_CENTER_Y, 0);
    write_register(REG_RADIUS_FIRST, 256);
    write_register(REG_START_PHASE, 0);
    send_time(17'd0, 1'b0);
    send_time(17'd32768, 1'b0);
    send_time(17'd0, 1'b0);
    drain_results();

    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n % 150 == 0) begin
        drain_results();
        random_config();
      end
      out_noidle = (n >= 600 && n < 800);
      send_time(random_time(), out_noidle);
    end

    drain_results();
    if (fail_count == 0) begin
      $display("parametric_path_point_generator verification clean");
    end else begin
      $display("parametric_path_point_generator verification failed");
    end
    $finish;
  end

endmodule
